// ===== design/sscc_pkg.sv =====
package sscc_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_Y_ENTRY = 2'd2,
    OP_END     = 2'd3
  } op_e;

  // Relation codes on the result
  typedef enum logic [1:0] {
    REL_NOT_CONTAINED = 2'd0,
    REL_EQUAL         = 2'd1,
    REL_CONTAINED     = 2'd2
  } rel_e;

  // Match modes held in the mode register
  localparam logic [1:0] MODE_EQUAL  = 2'd0;
  localparam logic [1:0] MODE_PROPER = 2'd1;
  localparam logic [1:0] MODE_SUBSET = 2'd2;

  // Configuration register indexes (byte address / 4)
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_BINARY = 1'b1;

  localparam int RowW    = 16;
  localparam int DegW    = 16;
  localparam int ColW    = 16;
  localparam int YLenW   = 17;

  // Rows at or above this bound are ignored; the column count wraps here
  localparam logic [RowW:0] MaxRows    = 17'd65536;
  localparam logic [ColW:0] MaxColumns = 17'd65536;

  localparam logic [YLenW-1:0] YLenMax = '1;

  // One stored X entry
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [DegW-1:0] deg;
  } x_entry_t;

endpackage

// ===== design/sscc_ram.sv =====
module sscc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sparse_set_containment_compare.sv =====
// Channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+----------------------------------------
// input    | in        | in_valid_i / in_stall_o  | opcode_i, row_index_i, degree_i
// result   | out       | out_valid_o / out_stall_i| column_number_o, relation_o, matched_o,
//          |           |                          | store_overflow_o
// config   | in        | APB (psel .. pready)     | relation_mode @0x0, binary_sets @0x4
//
// One beat per cycle sustained while no end-of-column beat waits on a stalled result.
// An accepted beat is held in the input register, where it is resolved against the X
// entry at the cursor; an end-of-column result is loaded into the output register when
// its beat leaves the input register, and is offered from there. The rate is set by the
// single compare against the store's registered read, whose address is the cursor's next
// value. Reset clears all counters and flags; the X store has no clearing pass and holds
// garbage until appended. A stalled result holds the input register only when it carries
// an end-of-column beat; other beats keep flowing behind a waiting result.
module sparse_set_containment_compare
  import sscc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [RowW-1:0]      row_index_i,
  input  logic [DegW-1:0]      degree_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ColW-1:0]      column_number_o,
  output logic [1:0]           relation_o,
  output logic                 matched_o,
  output logic                 store_overflow_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LenW  = $clog2(MAX_ENTRIES + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_ENTRIES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] mode_q;
  logic       binary_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SUBSET;
      binary_q <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MODE) begin
        mode_q <= pwdata[1:0];
      end else begin
        binary_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BINARY) begin
      prdata[0] = binary_q;
    end else begin
      prdata[1:0] = mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic            s1_valid_q;
  op_e             s1_op_q;
  logic [RowW-1:0] s1_row_q;
  logic [DegW-1:0] s1_deg_q;
  logic            out_valid_q;
  logic            out_free;
  logic            s1_fire;

  // Only an end-of-column beat needs the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && ((s1_op_q != OP_END) || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q  <= op_e'(opcode_i);
      s1_row_q <= row_index_i;
      s1_deg_q <= degree_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge state
  // ---------------------------------------------------------------------------
  logic [LenW-1:0]  x_len_q, x_len_d;
  logic [LenW-1:0]  cursor_q, cursor_d;
  logic [YLenW-1:0] y_len_q, y_len_d;
  logic             nc_q, nc_d;
  logic             yex_q, yex_d;
  logic [ColW-1:0]  cols_q, cols_d;
  logic             ovf_q, ovf_d;

  // X store: read address is the next cursor, so the entry at the cursor is
  // ready when the next beat is resolved
  logic     ram_we;
  x_entry_t ram_wdata;
  x_entry_t ram_rdata;
  logic     byp_q;
  x_entry_t byp_data_q;
  x_entry_t cur;

  sscc_ram #(
    .WIDTH ($bits(x_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_x_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (x_len_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (cursor_d[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Forward an append that lands on the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (cursor_d == x_len_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata;
  end

  assign cur = byp_q ? byp_data_q : ram_rdata;

  logic            row_ok;
  logic            cur_valid;
  logic            end_nc;
  rel_e            rel;
  logic            match;
  logic [ColW:0]   cols_inc;
  logic [YLenW-1:0] x_len_ext;

  assign row_ok    = {1'b0, s1_row_q} < MaxRows;
  assign cur_valid = cursor_q < x_len_q;
  assign ram_wdata = '{row: s1_row_q, deg: s1_deg_q};
  assign ram_we    = s1_fire && (s1_op_q == OP_APPEND) && row_ok && (x_len_q < MaxLen);
  assign x_len_ext = YLenW'(x_len_q);

  // End-of-column verdict
  always_comb begin
    end_nc = nc_q || cur_valid;
    if (end_nc) begin
      rel = REL_NOT_CONTAINED;
    end else if (yex_q) begin
      rel = REL_CONTAINED;
    end else begin
      rel = REL_EQUAL;
    end
    unique case (mode_q)
      MODE_EQUAL:  match = (rel == REL_EQUAL) && (y_len_q == x_len_ext);
      MODE_PROPER: match = (rel != REL_NOT_CONTAINED) && (y_len_q > x_len_ext);
      MODE_SUBSET: match = (rel != REL_NOT_CONTAINED) && (y_len_q >= x_len_ext);
      default:     match = 1'b0;
    endcase
    cols_inc = {1'b0, cols_q} + 1'b1;
    if (cols_inc >= MaxColumns) begin
      cols_inc = '0;
    end
  end

  // Next state for one beat
  always_comb begin
    x_len_d  = x_len_q;
    cursor_d = cursor_q;
    y_len_d  = y_len_q;
    nc_d     = nc_q;
    yex_d    = yex_q;
    cols_d   = cols_q;
    ovf_d    = ovf_q;
    if (s1_fire) begin
      unique case (s1_op_q)
        OP_CLEAR: begin
          x_len_d  = '0;
          cursor_d = '0;
          y_len_d  = '0;
          nc_d     = 1'b0;
          yex_d    = 1'b0;
          cols_d   = '0;
          ovf_d    = 1'b0;
        end
        OP_APPEND: begin
          if (row_ok) begin
            if (x_len_q < MaxLen) begin
              x_len_d = x_len_q + LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        OP_Y_ENTRY: begin
          if (row_ok) begin
            if (y_len_q != YLenMax) begin
              y_len_d = y_len_q + YLenW'(1);
            end
            if (!cur_valid) begin
              yex_d = 1'b1;
            end else if (cur.row < s1_row_q) begin
              nc_d = 1'b1;
            end else if (cur.row > s1_row_q) begin
              yex_d = 1'b1;
            end else begin
              if (!binary_q) begin
                if (cur.deg > s1_deg_q) begin
                  nc_d = 1'b1;
                end else if (cur.deg < s1_deg_q) begin
                  yex_d = 1'b1;
                end
              end
              cursor_d = cursor_q + LenW'(1);
            end
          end
        end
        OP_END: begin
          cursor_d = '0;
          y_len_d  = '0;
          nc_d     = 1'b0;
          yex_d    = 1'b0;
          cols_d   = cols_inc[ColW-1:0];
        end
        default: begin
          x_len_d = x_len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_len_q  <= '0;
      cursor_q <= '0;
      y_len_q  <= '0;
      nc_q     <= 1'b0;
      yex_q    <= 1'b0;
      cols_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      x_len_q  <= x_len_d;
      cursor_q <= cursor_d;
      y_len_q  <= y_len_d;
      nc_q     <= nc_d;
      yex_q    <= yex_d;
      cols_q   <= cols_d;
      ovf_q    <= ovf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on an end-of-column beat, drop when taken
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_num_q;
  rel_e            rel_q;
  logic            match_q;
  logic            ovf_out_q;
  logic            end_fire;

  assign end_fire = s1_fire && (s1_op_q == OP_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      col_num_q <= cols_inc[ColW-1:0];
      rel_q     <= rel;
      match_q   <= match;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign column_number_o  = col_num_q;
  assign relation_o       = rel_q;
  assign matched_o        = match_q;
  assign store_overflow_o = ovf_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_len_q <= MaxLen)
    else $error("X length beyond store capacity");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= x_len_q)
    else $error("cursor ran past the X length");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_op_q == OP_CLEAR) |=> (x_len_q == '0) && (cols_q == '0) && !ovf_q)
    else $error("clear did not empty the X set");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_fire |=> out_valid_q)
    else $error("end of column produced no result");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && (s1_op_q == OP_END) && out_valid_q)
    else $error("input stalled without a waiting result");

endmodule
